[rtl/core/krd_pkg.sv]
// Shared types and constants for the keypad release debouncer.
`timescale 1ns / 1ps
`default_nettype none

package krd_pkg;

   // Keys that the sampled level word carries
   localparam int unsigned SENSED_KEYS = 16;
   localparam int unsigned CNT_W       = 8;
   localparam int unsigned CODE_W      = 8;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODES_LO       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODES_HI       = 2'd2;

   // Register reset values
   localparam logic [CNT_W-1:0]      LIMIT_RESET    = 8'd5;
   localparam logic [CSR_DATA_W-1:0] CODES_LO_RESET = 64'h0706_0504_0302_0100;
   localparam logic [CSR_DATA_W-1:0] CODES_HI_RESET = 64'h0F0E_0D0C_0B0A_0908;

   // Beat kinds on the request channel
   localparam logic MODE_POLL = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [SENSED_KEYS-1:0] pressed_keys;
   } req_payload_type;

   typedef struct packed {
      logic              key_valid;
      logic [CODE_W-1:0] key_code;
   } rsp_payload_type;

endpackage

`default_nettype wire

[rtl/core/krd_if.sv]
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps
`default_nettype none

interface krd_req_if;
   logic                     valid;
   logic                     ready;
   krd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface krd_rsp_if;
   logic                     valid;
   logic                     ready;
   krd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/keypad_release_debouncer_top.sv]
// Keypad release debouncer: per-key press counters, release latch and read-out.
//
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-----------------------------------
//  req_chan  | in  | valid / ready    | mode, pressed_keys[15:0]
//  rsp_chan  | out | valid / ready    | key_valid, key_code[7:0]
//  csr_*     | in  | csr_we           | csr_index[1:0], csr_wdata[63:0]
//
// One beat per cycle sustained while responses are taken; a beat passes the input register
// (loaded on accept) and then the response register (loaded when the pipe advances).
// Counters, the latch and the priority pick update in the single pass between
// the input register and the response register.
// Reset is synchronous and active high: counters and latch clear, registers load defaults.
// A stalled response holds the pipe; the input register still takes a beat when it is empty.
`timescale 1ns / 1ps
`default_nettype none

module keypad_release_debouncer_top #(
   parameter int unsigned NUM_KEYS = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   krd_req_if.sink                           req_chan,
   krd_rsp_if.source                         rsp_chan,
   input  wire                               csr_we,
   input  wire [krd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [krd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import krd_pkg::*;

   // Configuration registers
   logic [CNT_W-1:0]      limit_ff;
   logic [CSR_DATA_W-1:0] codes_lo_ff;
   logic [CSR_DATA_W-1:0] codes_hi_ff;

   // Input register
   logic                   in_vld_ff;
   logic                   in_mode_ff;
   logic [SENSED_KEYS-1:0] in_keys_ff;

   // Key state
   logic [CNT_W-1:0]  cnt_ff [NUM_KEYS];
   logic [CNT_W-1:0]  cnt_in [NUM_KEYS];
   logic              latch_vld_ff;
   logic              latch_vld_in;
   logic [CODE_W-1:0] latch_code_ff;
   logic [CODE_W-1:0] latch_code_in;

   // Response register
   logic              out_vld_ff;
   rsp_payload_type   out_data_ff;
   rsp_payload_type   out_data_in;

   // Per-key decode
   logic [NUM_KEYS-1:0] held_w;
   logic [NUM_KEYS-1:0] qual_w;
   logic [NUM_KEYS-1:0] first_w;
   logic [CODE_W-1:0]   code_w [NUM_KEYS];
   logic [CODE_W-1:0]   pick_code;
   logic                any_qual;
   logic                advance;
   logic                do_poll;
   logic                do_read;

   // Advance the pipe when the response slot is free or being taken
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign do_poll        = advance && (in_mode_ff == MODE_POLL);
   assign do_read        = advance && (in_mode_ff == MODE_READ);

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         codes_lo_ff <= CODES_LO_RESET;
         codes_hi_ff <= CODES_HI_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE_LIMIT: limit_ff    <= csr_wdata[CNT_W-1:0];
            CSR_CODES_LO:       codes_lo_ff <= csr_wdata;
            CSR_CODES_HI:       codes_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture a request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_mode_ff <= req_chan.payload.mode;
         in_keys_ff <= req_chan.payload.pressed_keys;
      end
   end

   // Map each key to its level and reported code; keys past the sensed word read released
   for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
      if (g < 8) begin : g_lo
         assign code_w[g] = codes_lo_ff[CODE_W*g +: CODE_W];
      end else if (g < SENSED_KEYS) begin : g_hi
         assign code_w[g] = codes_hi_ff[CODE_W*(g-8) +: CODE_W];
      end else begin : g_none
         assign code_w[g] = '0;
      end
      if (g < SENSED_KEYS) begin : g_lvl
         assign held_w[g] = in_keys_ff[g];
      end else begin : g_nolvl
         assign held_w[g] = 1'b0;
      end
      assign qual_w[g] = !held_w[g] && (cnt_ff[g] >= limit_ff);
   end

   // Pick the lowest released key that reached the limit
   always_comb begin
      logic blocked;
      blocked   = 1'b0;
      pick_code = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         first_w[i] = qual_w[i] && !blocked;
         blocked    = blocked || qual_w[i];
         if (first_w[i]) begin
            pick_code = code_w[i];
         end
      end
      any_qual = blocked;
   end

   // Next counter values: keys above the picked one hold
   always_comb begin
      logic blocked;
      blocked = 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (do_poll && !blocked) begin
            if (held_w[i]) begin
               cnt_in[i] = (cnt_ff[i] >= limit_ff) ? limit_ff : cnt_ff[i] + 1'b1;
            end else if (first_w[i]) begin
               cnt_in[i] = '0;
            end
         end
         blocked = blocked || qual_w[i];
      end
   end

   // Latch update and response data
   always_comb begin
      latch_vld_in  = latch_vld_ff;
      latch_code_in = latch_code_ff;
      out_data_in   = '0;
      if (do_read) begin
         out_data_in.key_valid = latch_vld_ff;
         out_data_in.key_code  = latch_vld_ff ? latch_code_ff : '0;
         latch_vld_in          = 1'b0;
         latch_code_in         = '0;
      end else if (do_poll && any_qual) begin
         latch_vld_in  = 1'b1;
         latch_code_in = pick_code;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            cnt_ff[i] <= '0;
         end
         latch_vld_ff  <= 1'b0;
         latch_code_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         latch_vld_ff  <= latch_vld_in;
         latch_code_ff <= latch_code_in;
      end
   end

   // Response register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_chan.valid   = out_vld_ff;
   assign rsp_chan.payload = out_data_ff;

   // An empty latch always carries a zero code
   a_latch_clear: assert property (@(posedge clock) disable iff (reset)
      !latch_vld_ff |-> (latch_code_ff == '0))
      else $error("latch code not zero while latch empty");

   // A read leaves the latch empty
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      do_read |=> !latch_vld_ff)
      else $error("latch still set after read");

   // A response without a key reports a zero code
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_data_ff.key_valid) |-> (out_data_ff.key_code == '0))
      else $error("nonzero code on empty response");

   // Request side stalls only when both stages are full and the response is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (in_vld_ff && out_vld_ff && !rsp_chan.ready))
      else $error("request stalled without back pressure");

endmodule

`default_nettype wire
